// ----- hw/rtl/lpg_pkg.sv -----
// Shared constants and codes for the line pixel generator.
`default_nettype none
package lpg_pkg;
    localparam int COORD_BITS = 10;
    localparam int COLOR_BITS = 24;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;
endpackage
`default_nettype wire

// ----- hw/rtl/line_pixel_generator.sv -----
// Top level of the line pixel generator: command handling, sequencer, output register.
`default_nettype none
// A load transfer (operation 0) latches two endpoints and a pen color and emits
// nothing. Each advance transfer (operation 1) emits the next pixel of the active
// line, stepping the major axis by one; the minor coordinate comes from a shared
// multiply and radix-2 divide unit. An advance goes through these steps in order:
// accept, multiply, load the divider, COORD_BITS divide steps, write the output
// register once it is free. s_ready is low while a pixel is being computed. The
// output register holds a finished pixel until it is taken, and a new command may
// be accepted meanwhile. An advance with no active line is accepted with no output.
module line_pixel_generator #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS,
    parameter int COLOR_BITS = lpg_pkg::COLOR_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_operation,
    input  wire logic [COORD_BITS-1:0] s_start_x,
    input  wire logic [COORD_BITS-1:0] s_start_y,
    input  wire logic [COORD_BITS-1:0] s_end_x,
    input  wire logic [COORD_BITS-1:0] s_end_y,
    input  wire logic [COLOR_BITS-1:0] s_pen_color,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [COORD_BITS-1:0]      m_pixel_x,
    output logic [COORD_BITS-1:0]      m_pixel_y,
    output logic [COLOR_BITS-1:0]      m_pixel_color,
    output logic                       m_last_pixel
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [COORD_BITS-1:0] origin_x_reg, origin_y_reg, target_x_reg, target_y_reg;
    logic [COLOR_BITS-1:0] held_color_reg;
    logic [COORD_BITS-1:0] major_position_reg;
    logic                  steep_flag_reg, descending_flag_reg, line_active_reg;
    logic [COORD_BITS-1:0] quo_reg;
    logic                  m_valid_reg;

    logic                  s_fire, load_fire, adv_fire, emit_fire;
    logic [COORD_BITS:0]   in_dx, in_dy, in_adx, in_ady;
    logic                  in_steep;

    logic [COORD_BITS-1:0] s_major, e_major, s_minor, e_minor;
    logic [COORD_BITS:0]   dmaj, dmin;
    logic [COORD_BITS-1:0] dmaj_mag, dmin_mag, offset_mag;
    logic                  dmin_neg, dmaj_zero, emit_last;
    logic [COORD_BITS-1:0] minor, q_eff;
    logic                  div_done;
    logic [COORD_BITS-1:0] div_quotient;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign load_fire = s_fire && (s_operation == lpg_pkg::OP_LOAD);
    assign adv_fire  = s_fire && (s_operation == lpg_pkg::OP_ADVANCE) && line_active_reg;
    assign emit_fire = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    assign in_dx    = {1'b0, s_end_x} - {1'b0, s_start_x};
    assign in_dy    = {1'b0, s_end_y} - {1'b0, s_start_y};
    assign in_adx   = in_dx[COORD_BITS] ? -in_dx : in_dx;
    assign in_ady   = in_dy[COORD_BITS] ? -in_dy : in_dy;
    assign in_steep = (in_ady > in_adx);

    always_comb begin
        if (steep_flag_reg) begin
            s_major = origin_y_reg;
            e_major = target_y_reg;
            s_minor = origin_x_reg;
            e_minor = target_x_reg;
        end else begin
            s_major = origin_x_reg;
            e_major = target_x_reg;
            s_minor = origin_y_reg;
            e_minor = target_y_reg;
        end
    end

    assign dmaj       = {1'b0, e_major} - {1'b0, s_major};
    assign dmin       = {1'b0, e_minor} - {1'b0, s_minor};
    assign dmaj_mag   = dmaj[COORD_BITS] ? COORD_BITS'(-dmaj) : dmaj[COORD_BITS-1:0];
    assign dmin_mag   = dmin[COORD_BITS] ? COORD_BITS'(-dmin) : dmin[COORD_BITS-1:0];
    assign dmin_neg   = dmin[COORD_BITS];
    assign dmaj_zero  = (dmaj == '0);
    assign offset_mag = (major_position_reg >= s_major) ? (major_position_reg - s_major)
                                                        : (s_major - major_position_reg);
    assign emit_last  = (major_position_reg == e_major);
    assign q_eff      = dmaj_zero ? '0 : quo_reg;
    assign minor      = dmin_neg ? (s_minor - q_eff) : (s_minor + q_eff);

    lpg_muldiv #(
        .WIDTH(COORD_BITS)
    ) u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (adv_fire),
        .mul_a    (dmin_mag),
        .mul_b    (offset_mag),
        .divisor  (dmaj_mag),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (adv_fire) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            origin_x_reg        <= '0;
            origin_y_reg        <= '0;
            target_x_reg        <= '0;
            target_y_reg        <= '0;
            held_color_reg      <= '0;
            major_position_reg  <= '0;
            steep_flag_reg      <= 1'b0;
            descending_flag_reg <= 1'b0;
            line_active_reg     <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_fire) begin
                origin_x_reg        <= s_start_x;
                origin_y_reg        <= s_start_y;
                target_x_reg        <= s_end_x;
                target_y_reg        <= s_end_y;
                held_color_reg      <= s_pen_color;
                steep_flag_reg      <= in_steep;
                descending_flag_reg <= in_steep ? (s_end_y < s_start_y) : (s_end_x < s_start_x);
                major_position_reg  <= in_steep ? s_start_y : s_start_x;
                line_active_reg     <= 1'b1;
            end
            if (emit_fire) begin
                if (emit_last) begin
                    line_active_reg <= 1'b0;
                end else if (descending_flag_reg) begin
                    major_position_reg <= major_position_reg - 1'b1;
                end else begin
                    major_position_reg <= major_position_reg + 1'b1;
                end
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_done) begin
            quo_reg <= div_quotient;
        end
        if (emit_fire) begin
            m_pixel_x     <= steep_flag_reg ? minor : major_position_reg;
            m_pixel_y     <= steep_flag_reg ? major_position_reg : minor;
            m_pixel_color <= held_color_reg;
            m_last_pixel  <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_CALC))
        else $error("divider finished outside pixel computation");

    a_busy_needs_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC || state_reg == S_EMIT) |-> line_active_reg)
        else $error("pixel computation without an active line");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && emit_last) |=> !line_active_reg)
        else $error("line still active after its last pixel");

    a_idle_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == lpg_pkg::OP_ADVANCE && !line_active_reg)
            |=> (state_reg == S_IDLE))
        else $error("advance without a line started work");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> m_valid_reg)
        else $error("emitted pixel not presented");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/lpg_muldiv.sv -----
// Shared multiply and radix-2 restoring divide unit: (mul_a * mul_b) / divisor.
`default_nettype none
module lpg_muldiv #(
    parameter int WIDTH = lpg_pkg::COORD_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] mul_a,
    input  wire logic [WIDTH-1:0] mul_b,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient
);
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_LOAD = 2'd2;
    localparam logic [1:0] D_ITER = 2'd3;

    logic [1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg;
    logic [2*WIDTH-1:0] prod_reg;
    logic [WIDTH-1:0]   rem_reg;
    logic [WIDTH-1:0]   quo_reg;
    logic [WIDTH-1:0]   den_reg;
    logic [WIDTH-1:0]   mul_a_reg;
    logic [WIDTH-1:0]   mul_b_reg;

    logic [WIDTH:0]     trial;
    logic [WIDTH:0]     diff;
    logic               fits;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            D_IDLE: begin
                if (start) begin
                    phase_next = D_MUL;
                end
            end
            D_MUL:  phase_next = D_LOAD;
            D_LOAD: phase_next = D_ITER;
            D_ITER: begin
                if (count_reg == '0) begin
                    phase_next = D_IDLE;
                end
            end
            default: phase_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= D_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            D_IDLE: begin
                mul_a_reg <= mul_a;
                mul_b_reg <= mul_b;
                den_reg   <= divisor;
            end
            D_MUL: begin
                prod_reg <= mul_a_reg * mul_b_reg;
            end
            D_LOAD: begin
                // high half is below the divisor, so WIDTH quotient bits suffice
                rem_reg   <= prod_reg[2*WIDTH-1:WIDTH];
                quo_reg   <= prod_reg[WIDTH-1:0];
                count_reg <= CNT_W'(WIDTH - 1);
            end
            D_ITER: begin
                rem_reg   <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
                quo_reg   <= {quo_reg[WIDTH-2:0], fits};
                count_reg <= count_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign done     = (phase_reg == D_ITER) && (count_reg == '0);
    assign quotient = {quo_reg[WIDTH-2:0], fits};
endmodule
`default_nettype wire
